[hw/rtl/cpd_pkg.sv]
// ----------------------------------------------------------------------------
// cpd_pkg: shared types and constants of the CRC-16 packet deframer
// Transaction structs, verdict and item codes, frame layout constants and
// the byte-wide CRC-16/CCITT-FALSE update.
// ----------------------------------------------------------------------------
package cpd_pkg;

  // Configuration register indexes
  localparam int unsigned CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAGIC   = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_VERSION = 1'd1;
  localparam int unsigned CFG_DATA_W  = 8;

  // Result item kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  // Verdict codes
  localparam logic [2:0] VERDICT_OK           = 3'd0;
  localparam logic [2:0] VERDICT_TOO_SHORT    = 3'd1;
  localparam logic [2:0] VERDICT_BAD_HEADER   = 3'd2;
  localparam logic [2:0] VERDICT_LEN_MISMATCH = 3'd3;
  localparam logic [2:0] VERDICT_BAD_CRC      = 3'd4;

  // Frame layout
  localparam int unsigned POS_W        = 17;
  localparam logic [POS_W-1:0] POS_MAX = '1;
  localparam logic [POS_W-1:0] POS_MAGIC   = 17'd0;
  localparam logic [POS_W-1:0] POS_VERSION = 17'd1;
  localparam logic [POS_W-1:0] POS_TYPE    = 17'd2;
  localparam logic [POS_W-1:0] POS_SEQ     = 17'd3;
  localparam logic [POS_W-1:0] POS_LEN_LO  = 17'd4;
  localparam logic [POS_W-1:0] POS_LEN_HI  = 17'd5;
  localparam logic [POS_W-1:0] HEADER_LEN  = 17'd6;
  localparam logic [POS_W-1:0] MIN_LAST    = 17'd7;

  // CRC-16/CCITT-FALSE
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic        item_kind;
    logic [7:0]  payload_value;
    logic [2:0]  verdict;
    logic [7:0]  frame_type;
    logic [7:0]  frame_sequence;
    logic [15:0] frame_payload_length;
  } out_t;

  // One byte through the CRC, MSB first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

[hw/rtl/crc16_packet_deframer_top.sv]
// ----------------------------------------------------------------------------
// crc16_packet_deframer_top: streaming deframer for CRC-16 protected packets
// Checks magic, version, length and CRC-16/CCITT-FALSE of each received
// buffer, passes payload bytes on as they arrive and ends with a verdict.
//
//   Channel   Direction  Handshake             Payload
//   in        receive    in_valid / in_stall   cpd_pkg::in_t  (data_byte, last_byte)
//   out       send       out_valid / out_stall cpd_pkg::out_t (kind, payload, verdict, header)
//   cfg       receive    cfg_write             cfg_index, cfg_data (magic, version)
//
// One byte per cycle sustained while out does not stall. A byte is registered
// on entry and processed from the input register; its result, if any, is
// loaded into the output register. The byte-wide CRC update sits between the
// input register and the output register. Reset clears all frame state and
// loads magic and version with zero. A stall on out holds the output register
// and the input register, which raises in_stall.
// ----------------------------------------------------------------------------
module crc16_packet_deframer_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  cpd_pkg::in_t                       in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output cpd_pkg::out_t                      out_data,
  input  logic                               cfg_write,
  input  logic [cpd_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [cpd_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import cpd_pkg::*;

  logic [7:0] magic_value;
  logic [7:0] version_value;
  logic       item_valid;
  in_t        item;
  logic       advance;
  logic       step;
  logic       result_valid;
  out_t       result;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      magic_value   <= '0;
      version_value <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_MAGIC:   magic_value <= cfg_data;
        CFG_VERSION: version_value <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pipeline moves whenever the output register is free or draining
  assign advance  = !out_valid || !out_stall;
  assign step     = item_valid && advance;
  assign in_stall = item_valid && !advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item <= in_data;
    end
  end

  cpd_frame_tracker u_tracker (
    .clk           (clk),
    .rst           (rst),
    .step          (step),
    .item          (item),
    .magic_value   (magic_value),
    .version_value (version_value),
    .result_valid  (result_valid),
    .result        (result)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= step && result_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && step) begin
      out_data <= result;
    end
  end

  // A held input item and a free output register always make progress
  a_no_deadlock: assert property (@(posedge clk) disable iff (rst)
    item_valid && !out_valid |-> !in_stall)
    else $error("input held with empty output register");

  // A verdict output always carries zero payload
  a_verdict_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.item_kind == KIND_VERDICT |-> out_data.payload_value == '0)
    else $error("verdict with payload data");

  // A payload output always carries zero header fields
  a_payload_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.item_kind == KIND_PAYLOAD |->
      out_data.verdict == VERDICT_OK && out_data.frame_payload_length == '0)
    else $error("payload item with verdict fields");

endmodule

[hw/rtl/cpd_frame_tracker.sv]
// ----------------------------------------------------------------------------
// cpd_frame_tracker: per-frame state and combinational byte processing
// Tracks byte position, header fields, running CRC and received CRC, and
// forms the result of each payload or last byte: a tentative payload byte or a verdict.
// ----------------------------------------------------------------------------
module cpd_frame_tracker (
  input  logic          clk,
  input  logic          rst,
  input  logic          step,
  input  cpd_pkg::in_t  item,
  input  logic [7:0]    magic_value,
  input  logic [7:0]    version_value,
  output logic          result_valid,
  output cpd_pkg::out_t result
);
  import cpd_pkg::*;

  logic [POS_W-1:0] pos, pos_next;
  logic [15:0]      running_crc, running_crc_next;
  logic             header_ok, header_ok_next;
  logic [7:0]       held_type, held_type_next;
  logic [7:0]       held_sequence, held_sequence_next;
  logic [15:0]      held_length, held_length_next;
  logic [15:0]      received_crc, received_crc_next;

  logic [POS_W-1:0] crc_end;
  logic             in_crc;
  logic             is_payload;
  logic [7:0]       b;

  // Decode one byte against the current frame state
  always_comb begin
    b                  = item.data_byte;
    crc_end            = {1'b0, held_length} + HEADER_LEN;
    header_ok_next     = header_ok;
    held_type_next     = held_type;
    held_sequence_next = held_sequence;
    held_length_next   = held_length;
    running_crc_next   = running_crc;
    received_crc_next  = received_crc;

    case (pos)
      POS_MAGIC:   if (b != magic_value) header_ok_next = 1'b0;
      POS_VERSION: if (b != version_value) header_ok_next = 1'b0;
      POS_TYPE:    held_type_next = b;
      POS_SEQ:     held_sequence_next = b;
      POS_LEN_LO:  held_length_next = {held_length[15:8], b};
      POS_LEN_HI:  held_length_next = {b, held_length[7:0]};
      default: ;
    endcase

    in_crc     = pos < crc_end;
    is_payload = in_crc && (pos >= HEADER_LEN);
    if (in_crc) begin
      running_crc_next = crc_byte(running_crc, b);
    end else if (pos == crc_end) begin
      received_crc_next = {received_crc[15:8], b};
    end else if (pos == crc_end + 17'd1) begin
      received_crc_next = {b, received_crc[7:0]};
    end

    pos_next = (pos != POS_MAX) ? pos + 17'd1 : pos;

    // Form the result
    result       = '0;
    result_valid = item.last_byte || is_payload;
    if (item.last_byte) begin
      result.item_kind            = KIND_VERDICT;
      result.frame_type           = held_type_next;
      result.frame_sequence       = held_sequence_next;
      result.frame_payload_length = held_length_next;
      if (pos < MIN_LAST) begin
        result.verdict = VERDICT_TOO_SHORT;
      end else if (!header_ok_next) begin
        result.verdict = VERDICT_BAD_HEADER;
      end else if (pos == POS_MAX || pos != {1'b0, held_length_next} + MIN_LAST) begin
        result.verdict = VERDICT_LEN_MISMATCH;
      end else if (received_crc_next != running_crc_next) begin
        result.verdict = VERDICT_BAD_CRC;
      end else begin
        result.verdict = VERDICT_OK;
      end
    end else begin
      result.item_kind     = KIND_PAYLOAD;
      result.payload_value = b;
    end
  end

  // Advance frame state; clear it after a verdict
  always_ff @(posedge clk) begin
    if (rst || (step && item.last_byte)) begin
      pos           <= '0;
      running_crc   <= CRC_INIT;
      header_ok     <= 1'b1;
      held_type     <= '0;
      held_sequence <= '0;
      held_length   <= '0;
      received_crc  <= '0;
    end else if (step) begin
      pos           <= pos_next;
      running_crc   <= running_crc_next;
      header_ok     <= header_ok_next;
      held_type     <= held_type_next;
      held_sequence <= held_sequence_next;
      held_length   <= held_length_next;
      received_crc  <= received_crc_next;
    end
  end

  // A verdict returns the tracker to the start of a frame
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    step && item.last_byte |=> pos == '0 && running_crc == CRC_INIT && header_ok)
    else $error("frame state not cleared after last byte");

  // Payload is only reported past the header
  a_payload_after_header: assert property (@(posedge clk) disable iff (rst)
    step && result_valid && result.item_kind == KIND_PAYLOAD |-> pos >= HEADER_LEN)
    else $error("payload reported inside header");

  // The position counter holds at its maximum
  a_pos_saturates: assert property (@(posedge clk) disable iff (rst)
    step && !item.last_byte && pos == POS_MAX |=> pos == POS_MAX)
    else $error("byte position wrapped");

  // The length field cannot change once the header has passed
  a_length_stable: assert property (@(posedge clk) disable iff (rst)
    step && !item.last_byte && pos > POS_LEN_HI |=> $stable(held_length))
    else $error("length changed after header");

endmodule
